>>> design/rnvc_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helpers for the radius neighbor vote classifier.
// No dependencies; imported by the core, the checker and the bench.
package rnvc_pkg;

    localparam int CAPACITY  = 128;
    localparam int ADDR_W    = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    localparam int COORD_W   = 16;
    localparam int RADIUS_W  = 17;
    localparam int LIM_W     = 2 * (RADIUS_W + 1);
    localparam int SQ_W      = 2 * COORD_W;
    localparam int DIST_W    = SQ_W + 1;
    localparam int OCNT_W    = 8;
    localparam int VERDICT_W = 2;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 24;

    localparam logic [VERDICT_W-1:0] VERDICT_NONE = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_NO   = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_YES  = 2'd2;

    localparam logic LABEL_NO  = 1'b0;
    localparam logic LABEL_YES = 1'b1;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic                      label;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_x;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Report a neighbor count in eight bits, clamped.
    function automatic logic [OCNT_W-1:0] sat_count(input logic [CNT_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        if (w > 32'd255) begin
            return 8'hFF;
        end else begin
            return OCNT_W'(w);
        end
    endfunction

endpackage

>>> design/rnvc_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module rnvc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/radius_neighbor_vote_classifier_core.sv
`timescale 1ns / 1ps
// Radius neighbor vote classifier: labelled point store and query scan engine.
// Depends on rnvc_pkg and rnvc_ram.

// A load transaction appends its point and label to the store and answers
// from the finish state. A query transaction scans every stored point through
// one RAM read port, one point per cycle, followed by a three-stage distance
// pipeline, and the result is formed once the pipeline drains. The query
// point is appended with the majority label unless the vote ties or the store
// is full. The result waits in an output register; a new transaction is taken
// while it waits. The radius register may be written only while idle.
module radius_neighbor_vote_classifier_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [15:0] pos_x, [31:16] pos_y, [32] label_in, [39:33] zero
    input  logic [rnvc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [0] req_type
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [1:0] verdict, [9:2] yes_count, [17:10] no_count, [18] stored, [23:19] zero
    output logic [rnvc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rnvc_pkg::RADIUS_W-1:0]   i_cfg_data
);
    import rnvc_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic [CNT_W-1:0]    r_yes, n_yes;
    logic [CNT_W-1:0]    r_no, n_no;
    logic [RADIUS_W-1:0] r_radius;
    logic [LIM_W-1:0]    r_lim;
    logic [RADIUS_W:0]   radius_p1;

    logic                r_req;
    t_entry              r_item;

    // scan pipeline
    logic                r_p1_v, r_p2_v, r_p3_v;
    logic [COORD_W-1:0]  r_dx, r_dy;
    logic                r_p2_lab, r_p3_lab;
    logic [SQ_W-1:0]     r_sqx, r_sqy;

    logic                r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;

    logic                in_fire, out_free, issue, pipe_busy;
    logic                ram_we;
    t_entry              wr_entry, rd_entry;
    logic [COORD_W:0]    diff_x, diff_y;
    logic [COORD_W:0]    abs_x, abs_y;
    logic [DIST_W-1:0]   dist2;
    logic                hit;
    logic                full, want_store, do_store;
    logic [VERDICT_W-1:0] verdict;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign issue         = (r_state == ST_SCAN) && (r_idx < r_count);
    assign pipe_busy     = r_p1_v || r_p2_v || r_p3_v;
    assign full          = (r_count >= CNT_W'(CAPACITY));

    rnvc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_points (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (wr_entry),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (rd_entry)
    );

    // distance stages
    assign diff_x = {r_item.pos_x[COORD_W-1], r_item.pos_x}
                  - {rd_entry.pos_x[COORD_W-1], rd_entry.pos_x};
    assign diff_y = {r_item.pos_y[COORD_W-1], r_item.pos_y}
                  - {rd_entry.pos_y[COORD_W-1], rd_entry.pos_y};
    assign abs_x  = diff_x[COORD_W] ? (~diff_x + 1'b1) : diff_x;
    assign abs_y  = diff_y[COORD_W] ? (~diff_y + 1'b1) : diff_y;
    assign dist2  = DIST_W'(r_sqx) + DIST_W'(r_sqy);
    assign hit    = r_p3_v && (LIM_W'(dist2) < r_lim);
    assign radius_p1 = {1'b0, r_radius} + 1'b1;

    // decision for the finishing cycle
    always_comb begin
        verdict    = VERDICT_NONE;
        want_store = 1'b0;
        wr_entry   = r_item;
        if (r_req == REQ_LOAD) begin
            want_store = 1'b1;
        end else if (r_yes != r_no) begin
            want_store     = 1'b1;
            verdict        = (r_yes > r_no) ? VERDICT_YES : VERDICT_NO;
            wr_entry.label = (r_yes > r_no) ? LABEL_YES : LABEL_NO;
        end
    end

    assign do_store = want_store && !full;
    assign ram_we   = (r_state == ST_FINISH) && out_free && do_store;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_yes      = r_yes;
        n_no       = r_no;
        n_out_data = r_out_data;
        case (r_state)
            ST_IDLE: begin
                n_idx = '0;
                n_yes = '0;
                n_no  = '0;
                if (in_fire) begin
                    n_state = (s_axis_tuser == REQ_QUERY) ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    n_idx = r_idx + 1'b1;
                end
                if (hit) begin
                    if (r_p3_lab == LABEL_NO) begin
                        n_no = r_no + 1'b1;
                    end else begin
                        n_yes = r_yes + 1'b1;
                    end
                end
                if (!issue && !pipe_busy) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_out_data = OUT_DATA_W'({do_store, sat_count(r_no),
                                              sat_count(r_yes), verdict});
                    if (do_store) begin
                        n_count = r_count + 1'b1;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_yes       <= '0;
            r_no        <= '0;
            r_radius    <= '0;
            r_out_valid <= 1'b0;
            r_p1_v      <= 1'b0;
            r_p2_v      <= 1'b0;
            r_p3_v      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_yes   <= n_yes;
            r_no    <= n_no;
            if (i_cfg_valid && o_cfg_ready) begin
                r_radius <= i_cfg_data;
            end
            if ((r_state == ST_FINISH) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            r_p1_v <= issue;
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_lim      <= LIM_W'(radius_p1) * LIM_W'(radius_p1);
        r_out_data <= n_out_data;
        if (in_fire) begin
            r_req        <= s_axis_tuser;
            r_item.pos_x <= s_axis_tdata[COORD_W-1:0];
            r_item.pos_y <= s_axis_tdata[2*COORD_W-1:COORD_W];
            r_item.label <= s_axis_tdata[2*COORD_W];
        end
        r_dx     <= abs_x[COORD_W-1:0];
        r_dy     <= abs_y[COORD_W-1:0];
        r_p2_lab <= rd_entry.label;
        r_sqx    <= SQ_W'(r_dx) * SQ_W'(r_dx);
        r_sqy    <= SQ_W'(r_dy) * SQ_W'(r_dy);
        r_p3_lab <= r_p2_lab;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

>>> design/rnvc_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the radius neighbor vote classifier core, and the bind.
// Depends on rnvc_pkg and radius_neighbor_vote_classifier_core.
module rnvc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [rnvc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import rnvc_pkg::*;

    logic [VERDICT_W-1:0] verdict;
    logic [OCNT_W-1:0]    yes_cnt, no_cnt;

    assign verdict = m_axis_tdata[1:0];
    assign yes_cnt = m_axis_tdata[9:2];
    assign no_cnt  = m_axis_tdata[17:10];

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_tie_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && verdict == VERDICT_NONE |-> yes_cnt == no_cnt)
        else $error("no-verdict result with unequal counts");

    a_yes_majority: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && verdict == VERDICT_YES |-> yes_cnt >= no_cnt)
        else $error("yes verdict without yes majority");

    a_no_majority: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && verdict == VERDICT_NO |-> no_cnt >= yes_cnt)
        else $error("no verdict without no majority");

endmodule

bind radius_neighbor_vote_classifier_core rnvc_checker u_rnvc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> bench/tb_radius_neighbor_vote_classifier_core.sv
`timescale 1ns / 1ps
// Self-checking bench for radius_neighbor_vote_classifier_core: directed table, then
// clustered random loads and queries over several radius settings.
// Depends on rnvc_pkg and the core; results are scored against the table or an in-bench predictor.
module tb_radius_neighbor_vote_classifier_core;
    import rnvc_pkg::*;

    localparam int RAND_PHASES = 6;
    localparam int PHASE_ITEMS = 305;
    localparam int TAIL_CYCLES = CAPACITY + 40;
    localparam int MAX_SHOWN   = 10;
    localparam int NO_CHANGE   = -1;

    typedef struct {
        logic                      req;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      label;
    } t_point_req;

    // same layout as m_axis_tdata[18:0]
    typedef struct packed {
        logic              stored;
        logic [OCNT_W-1:0] no_cnt;
        logic [OCNT_W-1:0] yes_cnt;
        logic [1:0]        verdict;
    } t_vote;

    typedef struct {
        int         radius;
        t_point_req item;
        bit         known;
        t_vote      vote;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [15:0] pos_x, [31:16] pos_y, [32] label_in, [39:33] zero
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // [0] req_type
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [1:0] verdict, [9:2] yes_count, [17:10] no_count, [18] stored, [23:19] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [RADIUS_W-1:0]   i_cfg_data = '0;

    radius_neighbor_vote_classifier_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // predictor state
    logic [RADIUS_W-1:0] radius_q = '0;
    t_entry              store_q [CAPACITY];
    int                  fill_q = 0;
    t_vote               pending_votes [$];

    t_dir_row dir_rows [$];
    int send_idle = 0;
    int recv_idle = 0;
    int mismatches = 0;
    int n_load = 0, n_query = 0, n_radius = 0;
    int n_majority = 0, n_tie = 0, n_refused = 0;

    int cx [5] = '{-32768, -20000, 0, 12345, 32767};
    int cy [5] = '{32767, 7, 0, -15000, -32768};
    int spreads [5] = '{0, 3, 40, 700, 9000};
    int phase_radius [RAND_PHASES] = '{300, 0, 2500, 131071, 40, 1};

    task automatic flag_error(input string msg);
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endtask

    function automatic logic store_point(input logic signed [COORD_W-1:0] x,
                                         input logic signed [COORD_W-1:0] y,
                                         input logic label);
        if (fill_q >= CAPACITY) begin
            n_refused++;
            return 1'b0;
        end
        store_q[fill_q].pos_x = x;
        store_q[fill_q].pos_y = y;
        store_q[fill_q].label = label;
        fill_q++;
        return 1'b1;
    endfunction

    function automatic logic [OCNT_W-1:0] clamp_count(input int n);
        return (n > 255) ? 8'hFF : OCNT_W'(n);
    endfunction

    // Vote of one request against the current store; updates the store.
    function automatic t_vote predict_vote(input t_point_req it);
        t_vote  v;
        longint lim, dx, dy;
        int     yes_n, no_n;
        v = '0;
        yes_n = 0;
        no_n = 0;
        if (it.req == REQ_LOAD) begin
            v.verdict = VERDICT_NONE;
            v.stored = store_point(it.x, it.y, it.label);
        end else begin
            // floor(sqrt(d2)) <= r  <=>  d2 < (r+1)^2
            lim = (longint'(radius_q) + 1) * (longint'(radius_q) + 1);
            for (int i = 0; i < fill_q; i++) begin
                dx = longint'($signed(store_q[i].pos_x)) - longint'(it.x);
                dy = longint'($signed(store_q[i].pos_y)) - longint'(it.y);
                if (dx * dx + dy * dy < lim) begin
                    if (store_q[i].label == LABEL_NO) begin
                        no_n++;
                    end else begin
                        yes_n++;
                    end
                end
            end
            if (yes_n != no_n) begin
                v.verdict = (yes_n > no_n) ? VERDICT_YES : VERDICT_NO;
                v.stored = store_point(it.x, it.y, (yes_n > no_n) ? LABEL_YES : LABEL_NO);
            end else begin
                v.verdict = VERDICT_NONE;
            end
        end
        v.yes_cnt = clamp_count(yes_n);
        v.no_cnt = clamp_count(no_n);
        return v;
    endfunction

    function automatic void add_row(input int r, input logic req, input int x, input int y,
                                    input logic lab, input bit known, input logic [1:0] verd,
                                    input int yc, input int nc, input logic st);
        t_dir_row row;
        row.radius = r;
        row.item.req = req;
        row.item.x = COORD_W'(x);
        row.item.y = COORD_W'(y);
        row.item.label = lab;
        row.known = known;
        row.vote.verdict = verd;
        row.vote.yes_cnt = OCNT_W'(yc);
        row.vote.no_cnt = OCNT_W'(nc);
        row.vote.stored = st;
        dir_rows = {dir_rows, row};
    endfunction

    function automatic logic signed [COORD_W-1:0] near_coord(input int c, input int s);
        int v;
        v = c + int'($urandom_range(2 * s)) - s;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return COORD_W'(v);
    endfunction

    function automatic t_point_req random_item();
        t_point_req it;
        int k, s;
        it.req = ($urandom_range(99) < 25) ? REQ_LOAD : REQ_QUERY;
        it.label = 1'($urandom);
        if ($urandom_range(99) < 25) begin
            it.x = COORD_W'($urandom);
            it.y = COORD_W'($urandom);
        end else begin
            k = $urandom_range(4);
            s = spreads[$urandom_range(4)];
            it.x = near_coord(cx[k], s);
            it.y = near_coord(cy[k], s);
        end
        return it;
    endfunction

    // Leaves tvalid high on return; the caller lowers it or sends the next one.
    task automatic send_item(input t_point_req it, input bit known, input t_vote want);
        t_vote v;
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.req;
        s_axis_tdata  <= {7'b0, it.label, it.y, it.x};
        do @(posedge i_clk); while (!s_axis_tready);
        v = predict_vote(it);
        if (it.req == REQ_LOAD) n_load++; else n_query++;
        pending_votes = {pending_votes, (known ? want : v)};
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_votes.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_radius(input int r);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= RADIUS_W'(r);
        do @(posedge i_clk); while (!o_cfg_ready);
        radius_q = RADIUS_W'(r);
        n_radius++;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(input int mode);
        case (mode % 3)
            0: begin send_idle = 32; recv_idle = 62; end
            1: begin send_idle = 62; recv_idle = 32; end
            default: begin send_idle = 0; recv_idle = 0; end
        endcase
    endtask

    // result checker
    initial begin
        t_vote got, want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                got = t_vote'(m_axis_tdata[18:0]);
                if (pending_votes.size() == 0) begin
                    flag_error($sformatf("result with nothing expected: tdata=%h", m_axis_tdata));
                end else begin
                    want = pending_votes.pop_front();
                    if (want.verdict != VERDICT_NONE) n_majority++;
                    else if (want.yes_cnt != 0 || want.no_cnt != 0) n_tie++;
                    if (got.verdict != want.verdict || got.yes_cnt != want.yes_cnt ||
                        got.no_cnt != want.no_cnt || got.stored != want.stored ||
                        m_axis_tdata[OUT_DATA_W-1:19] != '0) begin
                        flag_error($sformatf({"exp verdict=%0d yes=%0d no=%0d stored=%0b, ",
                                              "got verdict=%0d yes=%0d no=%0d stored=%0b pad=%h"},
                            want.verdict, want.yes_cnt, want.no_cnt, want.stored,
                            got.verdict, got.yes_cnt, got.no_cnt, got.stored,
                            m_axis_tdata[OUT_DATA_W-1:19]));
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial begin
        t_vote none;
        none = '0;

        // empty store, loads at the corners, a duplicate point with opposite labels
        add_row(0, REQ_QUERY, 0, 0, 1'b1, 1, VERDICT_NONE, 0, 0, 1'b0);
        add_row(NO_CHANGE, REQ_LOAD, -32768, -32768, LABEL_YES, 1, VERDICT_NONE, 0, 0, 1'b1);
        add_row(NO_CHANGE, REQ_LOAD, 32767, 32767, LABEL_NO, 1, VERDICT_NONE, 0, 0, 1'b1);
        add_row(NO_CHANGE, REQ_LOAD, 0, 0, LABEL_YES, 1, VERDICT_NONE, 0, 0, 1'b1);
        add_row(NO_CHANGE, REQ_LOAD, 0, 0, LABEL_NO, 1, VERDICT_NONE, 0, 0, 1'b1);
        add_row(NO_CHANGE, REQ_QUERY, 0, 0, 1'b0, 0, VERDICT_NONE, 0, 0, 1'b0);
        add_row(NO_CHANGE, REQ_QUERY, -32768, -32768, 1'b0, 0, VERDICT_NONE, 0, 0, 1'b0);
        add_row(NO_CHANGE, REQ_QUERY, 32767, 32767, 1'b1, 0, VERDICT_NONE, 0, 0, 1'b0);
        add_row(131071, REQ_QUERY, 32767, -32768, 1'b0, 0, VERDICT_NONE, 0, 0, 1'b0);
        add_row(NO_CHANGE, REQ_LOAD, 1, 0, LABEL_NO, 1, VERDICT_NONE, 0, 0, 1'b1);
        add_row(NO_CHANGE, REQ_QUERY, -1, -1, 1'b1, 0, VERDICT_NONE, 0, 0, 1'b0);
        // radius 1 reaches a diagonal neighbor (truncated sqrt(2))
        add_row(1, REQ_QUERY, 1, 1, 1'b0, 0, VERDICT_NONE, 0, 0, 1'b0);
        add_row(NO_CHANGE, REQ_QUERY, 0, 1, 1'b1, 0, VERDICT_NONE, 0, 0, 1'b0);
        add_row(2, REQ_QUERY, -2, -2, 1'b0, 0, VERDICT_NONE, 0, 0, 1'b0);
        add_row(65535, REQ_QUERY, -32768, 0, 1'b0, 0, VERDICT_NONE, 0, 0, 1'b0);
        add_row(NO_CHANGE, REQ_QUERY, 32767, -32768, 1'b1, 0, VERDICT_NONE, 0, 0, 1'b0);
        // full diagonal is 92680.49: in at 92680, out at 92679
        add_row(92679, REQ_QUERY, 32767, 32767, 1'b0, 0, VERDICT_NONE, 0, 0, 1'b0);
        add_row(92680, REQ_QUERY, 32767, 32767, 1'b0, 0, VERDICT_NONE, 0, 0, 1'b0);
        add_row(NO_CHANGE, REQ_QUERY, -32768, -32768, 1'b1, 0, VERDICT_NONE, 0, 0, 1'b0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idling(0);
        foreach (dir_rows[i]) begin
            if (dir_rows[i].radius != NO_CHANGE) write_radius(dir_rows[i].radius);
            send_item(dir_rows[i].item, dir_rows[i].known, dir_rows[i].vote);
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            write_radius(phase_radius[ph]);
            set_idling(ph);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_item(random_item(), 0, none);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (pending_votes.size() != 0) begin
            flag_error($sformatf("%0d results never arrived", pending_votes.size()));
        end
        $display("Covered %0d loads and %0d queries over %0d radius writes.",
                 n_load, n_query, n_radius);
        $display("Votes: %0d majority, %0d ties with neighbors, %0d appends refused; %0d %s",
                 n_majority, n_tie, n_refused, mismatches, "mismatches.");
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #(100_000_000);
        $display("Some tests failed");
        $finish;
    end

endmodule

>>> files.f
design/rnvc_pkg.sv
design/rnvc_ram.sv
design/radius_neighbor_vote_classifier_core.sv
design/rnvc_checker.sv
bench/tb_radius_neighbor_vote_classifier_core.sv
